### design/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [5:0] POS_LAST   = 6'd3;
  localparam logic [5:0] CROSS_LAST = 6'd6;
  localparam logic [5:0] SQ_LAST    = 6'd3;
  localparam logic [5:0] SQRT_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST   = 6'd15;
  localparam logic [1:0] COMP_LAST  = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_WRITE, S_POS, S_EDGE, S_CROSS, S_SUM_RD, S_SUM_WR,
    S_RSUM, S_MAG, S_MAX, S_SCALE, S_SQ, S_SQRT, S_DIV_LOAD, S_DIV, S_DIV_STORE, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CLEAR, OP_WRITE, OP_POS, OP_EDGE, OP_CROSS, OP_SUM_RD, OP_SUM_WR,
    OP_RSUM, OP_MAG, OP_MAX, OP_SCALE, OP_SQ, OP_SQRT, OP_DIV_LOAD, OP_DIV, OP_DIV_STORE,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [5:0] step;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] code;
    logic       vi_ok;
    logic       tri_ok;
    logic       clear_last;
    logic       degen;
    logic       scaled;
  } dp_stat_t;

endpackage

### design/vertex_normal_accumulator_core.sv
// A write frees the input after storing its entry, a triangle after updating its corner sums.
// A read with a zero sum or an out-of-range index goes straight to its result; any other read
// passes the scaling shifter (one bit per cycle), the 32-step square root and three 16-step
// restoring divides; the input frees in the strobe cycle. One command is in flight at a time.
// After reset all VERTEX_DEPTH entries of the sum store are cleared, one per cycle, with busy high.
// Results appear for one cycle with out_valid; the receiver cannot stall them.
module vertex_normal_accumulator_core #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int SUM_WIDTH    = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [9:0]         in_vertex_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic [9:0]         in_tri_a,
  input  logic [9:0]         in_tri_b,
  input  logic [9:0]         in_tri_c,
  output logic               out_valid,
  output logic [9:0]         out_read_vertex,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic signed [15:0] out_unit_z,
  output logic               out_degenerate
);

  vna_pkg::dp_cmd_t  cmd;
  vna_pkg::dp_stat_t stat;

  vna_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  vna_datapath #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_tri_a        (in_tri_a),
    .in_tri_b        (in_tri_b),
    .in_tri_c        (in_tri_c),
    .out_valid       (out_valid),
    .out_read_vertex (out_read_vertex),
    .out_unit_x      (out_unit_x),
    .out_unit_y      (out_unit_y),
    .out_unit_z      (out_unit_z),
    .out_degenerate  (out_degenerate)
  );

endmodule

### design/vna_ctrl.sv
// Sequencing state machine for the vertex normal accumulator.
module vna_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output vna_pkg::dp_cmd_t   cmd,
  input  vna_pkg::dp_stat_t  stat
);

  vna_pkg::state_t state_r, state_nxt;
  logic [5:0]      step_r, step_nxt;
  logic [1:0]      sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::S_CLEAR;
      step_r  <= '0;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    sel_nxt   = sel_r;
    cmd.op    = vna_pkg::OP_NOP;
    cmd.step  = step_r;
    cmd.sel   = sel_r;
    unique case (state_r)
      vna_pkg::S_CLEAR: begin
        cmd.op = vna_pkg::OP_CLEAR;
        if (stat.clear_last) state_nxt = vna_pkg::S_IDLE;
      end
      vna_pkg::S_IDLE: begin
        if (start) begin
          cmd.op    = vna_pkg::OP_LOAD;
          state_nxt = vna_pkg::S_DISPATCH;
        end
      end
      vna_pkg::S_DISPATCH: begin
        unique case (stat.code)
          vna_pkg::CMD_WRITE: state_nxt = stat.vi_ok ? vna_pkg::S_WRITE : vna_pkg::S_IDLE;
          vna_pkg::CMD_TRI:   state_nxt = stat.tri_ok ? vna_pkg::S_POS : vna_pkg::S_IDLE;
          vna_pkg::CMD_READ:  state_nxt = vna_pkg::S_RSUM;
          default:            state_nxt = vna_pkg::S_IDLE;
        endcase
      end
      vna_pkg::S_WRITE: begin
        cmd.op    = vna_pkg::OP_WRITE;
        state_nxt = vna_pkg::S_IDLE;
      end
      vna_pkg::S_POS: begin
        cmd.op = vna_pkg::OP_POS;
        if (step_r == vna_pkg::POS_LAST) state_nxt = vna_pkg::S_EDGE;
        else step_nxt = step_r + 6'd1;
      end
      vna_pkg::S_EDGE: begin
        cmd.op    = vna_pkg::OP_EDGE;
        state_nxt = vna_pkg::S_CROSS;
      end
      vna_pkg::S_CROSS: begin
        cmd.op = vna_pkg::OP_CROSS;
        if (step_r == vna_pkg::CROSS_LAST) begin
          state_nxt = vna_pkg::S_SUM_RD;
          sel_nxt   = '0;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      vna_pkg::S_SUM_RD: begin
        cmd.op    = vna_pkg::OP_SUM_RD;
        state_nxt = vna_pkg::S_SUM_WR;
      end
      vna_pkg::S_SUM_WR: begin
        cmd.op = vna_pkg::OP_SUM_WR;
        if (sel_r == vna_pkg::COMP_LAST) begin
          state_nxt = vna_pkg::S_IDLE;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = vna_pkg::S_SUM_RD;
        end
      end
      vna_pkg::S_RSUM: begin
        cmd.op    = vna_pkg::OP_RSUM;
        state_nxt = vna_pkg::S_MAG;
      end
      vna_pkg::S_MAG: begin
        cmd.op    = vna_pkg::OP_MAG;
        state_nxt = vna_pkg::S_MAX;
      end
      vna_pkg::S_MAX: begin
        cmd.op    = vna_pkg::OP_MAX;
        state_nxt = stat.degen ? vna_pkg::S_OUT : vna_pkg::S_SCALE;
      end
      vna_pkg::S_SCALE: begin
        cmd.op = vna_pkg::OP_SCALE;
        if (stat.scaled) state_nxt = vna_pkg::S_SQ;
      end
      vna_pkg::S_SQ: begin
        cmd.op = vna_pkg::OP_SQ;
        if (step_r == vna_pkg::SQ_LAST) state_nxt = vna_pkg::S_SQRT;
        else step_nxt = step_r + 6'd1;
      end
      vna_pkg::S_SQRT: begin
        cmd.op = vna_pkg::OP_SQRT;
        if (step_r == vna_pkg::SQRT_LAST) begin
          state_nxt = vna_pkg::S_DIV_LOAD;
          sel_nxt   = '0;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      vna_pkg::S_DIV_LOAD: begin
        cmd.op    = vna_pkg::OP_DIV_LOAD;
        state_nxt = vna_pkg::S_DIV;
      end
      vna_pkg::S_DIV: begin
        cmd.op = vna_pkg::OP_DIV;
        if (step_r == vna_pkg::DIV_LAST) state_nxt = vna_pkg::S_DIV_STORE;
        else step_nxt = step_r + 6'd1;
      end
      vna_pkg::S_DIV_STORE: begin
        cmd.op = vna_pkg::OP_DIV_STORE;
        if (sel_r == vna_pkg::COMP_LAST) begin
          state_nxt = vna_pkg::S_OUT;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = vna_pkg::S_DIV_LOAD;
        end
      end
      vna_pkg::S_OUT: begin
        cmd.op    = vna_pkg::OP_OUT;
        state_nxt = vna_pkg::S_IDLE;
      end
      default: state_nxt = vna_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != vna_pkg::S_IDLE);

endmodule

### design/vna_datapath.sv
// Position and sum stores, cross product, normalization and divider datapath.
module vna_datapath #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int SUM_WIDTH    = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vna_pkg::dp_cmd_t    cmd,
  output vna_pkg::dp_stat_t   stat,
  input  logic [1:0]          in_command,
  input  logic [9:0]          in_vertex_index,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic signed [15:0]  in_pos_z,
  input  logic [9:0]          in_tri_a,
  input  logic [9:0]          in_tri_b,
  input  logic [9:0]          in_tri_c,
  output logic                out_valid,
  output logic [9:0]          out_read_vertex,
  output logic signed [15:0]  out_unit_x,
  output logic signed [15:0]  out_unit_y,
  output logic signed [15:0]  out_unit_z,
  output logic                out_degenerate
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int SW = SUM_WIDTH;
  localparam logic [SW-1:0] M_HI = SW'(64'd1 << 30);
  localparam logic [SW-1:0] M_LO = SW'(64'd1 << 29);

  // Latched command beat.
  logic [1:0]    code_r;
  logic [9:0]    vi_r;
  logic [AW-1:0] vi_addr_r;
  logic          vi_ok_r;
  logic [47:0]   pos_in_r;
  logic [AW-1:0] tri_addr_r [3];
  logic          tri_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.op == vna_pkg::OP_LOAD) begin
      code_r        <= in_command;
      vi_r          <= in_vertex_index;
      vi_addr_r     <= AW'(32'(in_vertex_index));
      vi_ok_r       <= (32'(in_vertex_index) < 32'(VERTEX_DEPTH));
      pos_in_r      <= {in_pos_z, in_pos_y, in_pos_x};
      tri_addr_r[0] <= AW'(32'(in_tri_a));
      tri_addr_r[1] <= AW'(32'(in_tri_b));
      tri_addr_r[2] <= AW'(32'(in_tri_c));
      tri_ok_r      <= (32'(in_tri_a) < 32'(VERTEX_DEPTH)) &&
                       (32'(in_tri_b) < 32'(VERTEX_DEPTH)) &&
                       (32'(in_tri_c) < 32'(VERTEX_DEPTH));
    end
  end

  logic [1:0] sidx, cidx;
  assign sidx = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];
  assign cidx = (cmd.sel == 2'd3) ? 2'd0 : cmd.sel;

  // Position store.
  logic [47:0] pos_mem [VERTEX_DEPTH];
  logic [47:0] pos_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.op == vna_pkg::OP_WRITE) pos_mem[vi_addr_r] <= pos_in_r;
    pos_rd_r <= pos_mem[tri_addr_r[sidx]];
  end

  // Sum store: x in the low slice, then y, then z.
  logic [3*SW-1:0] sum_mem [VERTEX_DEPTH];
  logic [3*SW-1:0] sum_rd_r;
  logic            sum_we;
  logic [AW-1:0]   sum_waddr, sum_raddr;
  logic [3*SW-1:0] sum_wdata, sat_sum;
  logic [AW-1:0]   clr_addr_r;
  logic signed [34:0] n_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [SW:0]   wide;
      logic [SW-1:0]        a;
      a    = sum_rd_r[c*SW +: SW];
      wide = $signed({a[SW-1], a}) + n_r[c];
      if (wide[SW] != wide[SW-1]) begin
        sat_sum[c*SW +: SW] = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        sat_sum[c*SW +: SW] = wide[SW-1:0];
      end
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = vi_addr_r;
    sum_wdata = '0;
    sum_raddr = (cmd.op == vna_pkg::OP_RSUM) ? vi_addr_r : tri_addr_r[cidx];
    unique case (cmd.op)
      vna_pkg::OP_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_addr_r;
      end
      vna_pkg::OP_WRITE: sum_we = 1'b1;
      vna_pkg::OP_SUM_WR: begin
        sum_we    = 1'b1;
        sum_waddr = tri_addr_r[cidx];
        sum_wdata = sat_sum;
      end
      default: sum_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rd_r <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.op == vna_pkg::OP_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
  end

  // Triangle: corner positions, edges and the cross product on one multiplier.
  logic [47:0]        pv_r [3];
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod_r;
  logic [2:0]         prev;

  always_comb begin
    unique case (cmd.step[2:0])
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
      3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
      3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
      default: begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
    endcase
  end

  assign prev = cmd.step[2:0] - 3'd1;

  always_ff @(posedge clk) begin
    if (cmd.op == vna_pkg::OP_POS && cmd.step[1:0] != 2'd0) begin
      pv_r[cmd.step[1:0] - 2'd1] <= pos_rd_r;
    end
    if (cmd.op == vna_pkg::OP_EDGE) begin
      for (int c = 0; c < 3; c++) begin
        e1_r[c] <= $signed(pv_r[1][c*16 +: 16]) - $signed(pv_r[0][c*16 +: 16]);
        e2_r[c] <= $signed(pv_r[2][c*16 +: 16]) - $signed(pv_r[0][c*16 +: 16]);
      end
    end
    if (cmd.op == vna_pkg::OP_CROSS) begin
      prod_r <= mul_a * mul_b;
      // Even products open a component, odd ones are subtracted from it.
      if (cmd.step[2:0] != 3'd0) begin
        if (!prev[0]) n_r[prev[2:1]] <= 35'(prod_r);
        else n_r[prev[2:1]] <= n_r[prev[2:1]] - 35'(prod_r);
      end
    end
  end

  // Read: magnitudes, common scaling, length and per-component divide.
  logic [SW-1:0] m_r [3];
  logic [2:0]    sgn_r;
  logic          deg_r;
  logic [SW-1:0] mmax_r;
  logic [59:0]   sq_r;
  logic [61:0]   acc_r;
  logic [63:0]   rem_r, res_r, bit_r, sq_t;
  logic [31:0]   len;
  logic [47:0]   num_r, dsh;
  logic [15:0]   q_r;
  logic [3:0]    qbit;
  logic [15:0]   unit_r [3];
  logic [SW-1:0] mx01;
  logic          scaled;

  assign len    = res_r[31:0];
  assign sq_t   = res_r + bit_r;
  assign qbit   = 4'd15 - cmd.step[3:0];
  assign dsh    = 48'(len) << qbit;
  assign mx01   = (m_r[1] > m_r[0]) ? m_r[1] : m_r[0];
  assign scaled = (mmax_r >= M_LO) && (mmax_r < M_HI);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      vna_pkg::OP_MAG: begin
        for (int c = 0; c < 3; c++) begin
          sgn_r[c] <= sum_rd_r[c*SW + SW - 1];
          m_r[c]   <= sum_rd_r[c*SW + SW - 1] ? (~sum_rd_r[c*SW +: SW] + SW'(1))
                                              : sum_rd_r[c*SW +: SW];
        end
        deg_r <= (sum_rd_r == '0) || !vi_ok_r;
      end
      vna_pkg::OP_MAX: mmax_r <= (m_r[2] > mx01) ? m_r[2] : mx01;
      vna_pkg::OP_SCALE: begin
        // Right shifts one bit at a time truncate the same as one wide shift.
        if (mmax_r >= M_HI) begin
          for (int c = 0; c < 3; c++) m_r[c] <= m_r[c] >> 1;
          mmax_r <= mmax_r >> 1;
        end else if (mmax_r < M_LO) begin
          for (int c = 0; c < 3; c++) m_r[c] <= m_r[c] << 1;
          mmax_r <= mmax_r << 1;
        end
      end
      vna_pkg::OP_SQ: begin
        sq_r <= m_r[sidx][29:0] * m_r[sidx][29:0];
        if (cmd.step[1:0] == 2'd0) begin
          acc_r <= '0;
        end else if (cmd.step[1:0] == 2'd3) begin
          rem_r <= 64'(acc_r) + 64'(sq_r);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end else begin
          acc_r <= acc_r + 62'(sq_r);
        end
      end
      vna_pkg::OP_SQRT: begin
        if (rem_r >= sq_t) begin
          rem_r <= rem_r - sq_t;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      vna_pkg::OP_DIV_LOAD: begin
        num_r <= {4'd0, m_r[cidx][29:0], 14'd0} + 48'(len >> 1);
        q_r   <= '0;
      end
      vna_pkg::OP_DIV: begin
        if (num_r >= dsh) begin
          num_r     <= num_r - dsh;
          q_r[qbit] <= 1'b1;
        end
      end
      vna_pkg::OP_DIV_STORE: unit_r[cidx] <= sgn_r[cidx] ? (~q_r + 16'd1) : q_r;
      default: ;
    endcase
  end

  // Result beat.
  logic        out_valid_r;
  logic [9:0]  out_vi_r;
  logic [15:0] out_x_r, out_y_r, out_z_r;
  logic        out_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= (cmd.op == vna_pkg::OP_OUT);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == vna_pkg::OP_OUT) begin
      out_vi_r  <= vi_r;
      out_x_r   <= deg_r ? 16'd0 : unit_r[0];
      out_y_r   <= deg_r ? 16'd0 : unit_r[1];
      out_z_r   <= deg_r ? 16'd0 : unit_r[2];
      out_deg_r <= deg_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_vertex = out_vi_r;
  assign out_unit_x      = out_x_r;
  assign out_unit_y      = out_y_r;
  assign out_unit_z      = out_z_r;
  assign out_degenerate  = out_deg_r;

  assign stat.code       = code_r;
  assign stat.vi_ok      = vi_ok_r;
  assign stat.tri_ok     = tri_ok_r;
  assign stat.clear_last = (32'(clr_addr_r) == 32'(VERTEX_DEPTH - 1));
  assign stat.degen      = deg_r;
  assign stat.scaled     = scaled;

endmodule

### test/vertex_normal_accumulator_core_test.sv
// Self-checking testbench for the vertex normal accumulator core.
`timescale 1ns / 1ps

module vertex_normal_accumulator_core_test;

  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic [9:0]         vtx;
    logic signed [15:0] px, py, pz;
    logic [9:0]         ta, tb, tc;
  } command_t;

  typedef struct {
    logic [9:0]         vtx;
    logic signed [15:0] ux, uy, uz;
    logic               degen;
  } normal_t;

  typedef struct {
    command_t item;
    bit       typed;
    normal_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = vna_pkg::CMD_WRITE;
  logic [9:0] in_vertex_index = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [9:0] in_tri_a = '0, in_tri_b = '0, in_tri_c = '0;
  logic out_valid;
  logic [9:0] out_read_vertex;
  logic signed [15:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_degenerate;

  vertex_normal_accumulator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_vertex_index(in_vertex_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_tri_a(in_tri_a), .in_tri_b(in_tri_b), .in_tri_c(in_tri_c),
    .out_valid(out_valid), .out_read_vertex(out_read_vertex),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_degenerate(out_degenerate)
  );

  always #4 clk = ~clk;

  // Shadow copy of the vertex stores.
  logic signed [15:0] vert_x [1024];
  logic signed [15:0] vert_y [1024];
  logic signed [15:0] vert_z [1024];
  longint             acc_x [1024];
  longint             acc_y [1024];
  longint             acc_z [1024];
  bit                 placed [1024];
  int                 placed_list [$];

  normal_t pending_normals [$];
  row_t    directed_rows [$];
  int      mismatches = 0;
  int      n_write = 0, n_tri = 0, n_read = 0, n_degen = 0, n_checked = 0;
  int      idle_cycles = 0;

  function automatic longint sat_sum(longint a, longint b);
    longint hi, lo, r;
    hi = (64'sd1 <<< 47) - 1;
    lo = -hi - 1;
    r = a + b;
    if (r > hi) return hi;
    if (r < lo) return lo;
    return r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] unit_part(longint s, longint unsigned m,
                                                   longint unsigned len);
    longint unsigned q;
    q = (m * 16384 + len / 2) / len;
    if (s < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic normal_t normalize_sum(logic [9:0] v);
    normal_t n;
    longint sx, sy, sz;
    longint unsigned mx, my, mz, mmax, len;
    int p, sh;
    sx = acc_x[v];
    sy = acc_y[v];
    sz = acc_z[v];
    n.vtx = v;
    n.ux = '0;
    n.uy = '0;
    n.uz = '0;
    n.degen = 1'b1;
    if (sx == 0 && sy == 0 && sz == 0) return n;
    mx = sx < 0 ? -sx : sx;
    my = sy < 0 ? -sy : sy;
    mz = sz < 0 ? -sz : sz;
    mmax = mx;
    if (my > mmax) mmax = my;
    if (mz > mmax) mmax = mz;
    p = 0;
    while (p < 63 && (mmax >> (p + 1)) != 0) p++;
    // Bring the largest magnitude into [2^29, 2^30) before the square root.
    sh = p - 29;
    if (sh > 0) begin
      mx >>= sh; my >>= sh; mz >>= sh;
    end else if (sh < 0) begin
      mx <<= -sh; my <<= -sh; mz <<= -sh;
    end
    len = root_floor(mx * mx + my * my + mz * mz);
    if (len == 0) len = 1;
    n.ux = unit_part(sx, mx, len);
    n.uy = unit_part(sy, my, len);
    n.uz = unit_part(sz, mz, len);
    n.degen = 1'b0;
    return n;
  endfunction

  // Applies one accepted beat to the shadow stores; returns 1 when a read result is due.
  function automatic bit apply_command(command_t c, output normal_t n);
    longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
    logic [9:0] corner [3];
    n = '{default: '0};
    case (c.cmd)
      vna_pkg::CMD_WRITE: begin
        vert_x[c.vtx] = c.px;
        vert_y[c.vtx] = c.py;
        vert_z[c.vtx] = c.pz;
        acc_x[c.vtx] = 0;
        acc_y[c.vtx] = 0;
        acc_z[c.vtx] = 0;
        if (!placed[c.vtx]) placed_list.push_back(c.vtx);
        placed[c.vtx] = 1'b1;
        n_write++;
      end
      vna_pkg::CMD_TRI: begin
        corner = '{c.ta, c.tb, c.tc};
        e1x = longint'(vert_x[c.tb]) - longint'(vert_x[c.ta]);
        e1y = longint'(vert_y[c.tb]) - longint'(vert_y[c.ta]);
        e1z = longint'(vert_z[c.tb]) - longint'(vert_z[c.ta]);
        e2x = longint'(vert_x[c.tc]) - longint'(vert_x[c.ta]);
        e2y = longint'(vert_y[c.tc]) - longint'(vert_y[c.ta]);
        e2z = longint'(vert_z[c.tc]) - longint'(vert_z[c.ta]);
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        foreach (corner[k]) begin
          acc_x[corner[k]] = sat_sum(acc_x[corner[k]], cx);
          acc_y[corner[k]] = sat_sum(acc_y[corner[k]], cy);
          acc_z[corner[k]] = sat_sum(acc_z[corner[k]], cz);
        end
        n_tri++;
      end
      vna_pkg::CMD_READ: begin
        n = normalize_sum(c.vtx);
        n_read++;
        if (n.degen) n_degen++;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Drives one beat at the falling edge and holds it until the core takes it.
  task automatic send_command(command_t c, bit typed, normal_t want);
    normal_t n;
    @(negedge clk);
    start = 1'b1;
    in_command = c.cmd;
    in_vertex_index = c.vtx;
    in_pos_x = c.px;
    in_pos_y = c.py;
    in_pos_z = c.pz;
    in_tri_a = c.ta;
    in_tri_b = c.tb;
    in_tri_c = c.tc;
    do @(posedge clk); while (busy);
    if (apply_command(c, n)) pending_normals.push_back(typed ? want : n);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic command_t make_cmd(logic [1:0] cmd, logic [9:0] vtx, int px, int py,
                                        int pz, logic [9:0] ta, logic [9:0] tb,
                                        logic [9:0] tc);
    command_t c;
    c.cmd = cmd;
    c.vtx = vtx;
    c.px = px[15:0];
    c.py = py[15:0];
    c.pz = pz[15:0];
    c.ta = ta;
    c.tb = tb;
    c.tc = tc;
    return c;
  endfunction

  function automatic void add_row(command_t c);
    row_t r;
    r.item = c;
    r.typed = 1'b0;
    r.want = '{default: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked_row(command_t c, int ux, int uy, int uz, bit degen);
    row_t r;
    r.item = c;
    r.typed = 1'b1;
    r.want.vtx = c.vtx;
    r.want.ux = ux[15:0];
    r.want.uy = uy[15:0];
    r.want.uz = uz[15:0];
    r.want.degen = degen;
    directed_rows.push_back(r);
  endfunction

  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return $urandom_range(0, 65535) - 32768;
    if (sel == 1) return $urandom_range(0, 1) ? 32767 : -32768;
    return $urandom_range(0, 4095) - 2048;
  endfunction

  function automatic logic [9:0] pick_placed();
    return 10'(placed_list[$urandom_range(0, placed_list.size() - 1)]);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int sel;
    c = make_cmd(vna_pkg::CMD_WRITE, 10'($urandom_range(0, 1023)), rand_coord(),
                 rand_coord(), rand_coord(), 10'($urandom_range(0, 1023)),
                 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      c.cmd = vna_pkg::CMD_WRITE;
      // Most writes land on a small set so triangles pile up on shared vertices.
      if ($urandom_range(0, 3) != 0) c.vtx = 10'($urandom_range(0, 31));
    end else if (sel < 70 && placed_list.size() > 0) begin
      c.cmd = vna_pkg::CMD_TRI;
      c.ta = pick_placed();
      c.tb = pick_placed();
      c.tc = pick_placed();
    end else if (sel < 95) begin
      c.cmd = vna_pkg::CMD_READ;
      if (placed_list.size() > 0 && $urandom_range(0, 3) != 0)
        c.vtx = pick_placed();
    end else begin
      c.cmd = CMD_UNUSED;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    normal_t w;
    if (rst_n && out_valid) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected read_vertex", out_read_vertex, -1);
      end else begin
        w = pending_normals.pop_front();
        n_checked++;
        if (out_read_vertex !== w.vtx) report_mismatch("read_vertex", out_read_vertex, w.vtx);
        if (out_unit_x !== w.ux) report_mismatch("unit_x", out_unit_x, w.ux);
        if (out_unit_y !== w.uy) report_mismatch("unit_y", out_unit_y, w.uy);
        if (out_unit_z !== w.uz) report_mismatch("unit_z", out_unit_z, w.uz);
        if (out_degenerate !== w.degen) report_mismatch("degenerate", out_degenerate, w.degen);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL vertex_normal_accumulator_core");
      $finish;
    end
  end

  initial begin
    command_t c;
    int burst;
    int sent;
    foreach (placed[i]) begin
      placed[i] = 1'b0;
      acc_x[i] = 0;
      acc_y[i] = 0;
      acc_z[i] = 0;
      vert_x[i] = '0;
      vert_y[i] = '0;
      vert_z[i] = '0;
    end

    // Axis-aligned faces give normals that can be read straight off.
    add_checked_row(make_cmd(vna_pkg::CMD_READ, 5, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1);
    add_row(make_cmd(vna_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 1, 256, 0, 0, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 2, 0, 256, 0, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_TRI, 0, 0, 0, 0, 0, 1, 2));
    add_checked_row(make_cmd(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 16384, 0);
    add_checked_row(make_cmd(vna_pkg::CMD_READ, 1, 0, 0, 0, 0, 0, 0), 0, 0, 16384, 0);
    // The reversed winding cancels the sum exactly, so the read is degenerate.
    add_row(make_cmd(vna_pkg::CMD_TRI, 0, 0, 0, 0, 0, 2, 1));
    add_checked_row(make_cmd(vna_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1);
    add_row(make_cmd(vna_pkg::CMD_WRITE, 4, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 5, 0, 0, 256, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 6, 0, 256, 0, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_TRI, 0, 0, 0, 0, 4, 5, 6));
    add_checked_row(make_cmd(vna_pkg::CMD_READ, 4, 0, 0, 0, 0, 0, 0), -16384, 0, 0, 0);
    add_row(make_cmd(vna_pkg::CMD_WRITE, 1023, 32767, -32768, 32767, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 512, -32768, 32767, -32768, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 341, -1, 1, 21845, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_TRI, 0, 0, 0, 0, 1023, 512, 341));
    add_row(make_cmd(vna_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(vna_pkg::CMD_READ, 341, 0, 0, 0, 0, 0, 0));
    // Repeated corners give a zero face, so the sums stay where they were.
    add_row(make_cmd(vna_pkg::CMD_TRI, 0, 0, 0, 0, 1023, 1023, 512));
    add_row(make_cmd(vna_pkg::CMD_READ, 512, 0, 0, 0, 0, 0, 0));
    add_row(make_cmd(CMD_UNUSED, 1023, -1, -1, -1, 1023, 1023, 1023));
    add_row(make_cmd(vna_pkg::CMD_WRITE, 1023, 0, 0, 0, 0, 0, 0));
    add_checked_row(make_cmd(vna_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_command(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        c = random_command();
        send_command(c, 1'b0, '{default: '0});
        sent++;
      end
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
        // Hold off until the core has drained every outstanding read.
        @(negedge clk);
        start = 1'b0;
        while (pending_normals.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 15));
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Covered %0d writes, %0d triangles and %0d reads (%0d degenerate).",
             n_write, n_tri, n_read, n_degen);
    $display("Checked %0d normals, %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("PASS vertex_normal_accumulator_core");
    end else begin
      $display("FAIL vertex_normal_accumulator_core");
    end
    $finish;
  end

endmodule

### sim.f
design/vna_pkg.sv
design/vna_ctrl.sv
design/vna_datapath.sv
design/vertex_normal_accumulator_core.sv
test/vertex_normal_accumulator_core_test.sv
